>>> rtl/jmv_pkg.sv
// Shared types, codes and constants for the jet multiplicity / VBF categorizer.
package jmv_pkg;

  localparam int JMV_MAX_JET_COUNT = 255;
  localparam int JMV_MID_DEPTH     = 4;
  localparam int JMV_OUT_DEPTH     = 4;

  // register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_PT_THR   = 2'd1;
  localparam logic [1:0] REG_GAP_CUT  = 2'd2;
  localparam logic [1:0] REG_MASS_CUT = 2'd3;

  localparam logic [2:0]  RST_MODE     = 3'd0;
  localparam logic [15:0] RST_PT_THR   = 16'd120;
  localparam logic [11:0] RST_GAP_CUT  = 12'd1024;
  localparam logic [15:0] RST_MASS_CUT = 16'd2000;

  // input opcodes
  localparam logic OPC_JET = 1'b0;
  localparam logic OPC_END = 1'b1;

  // category modes
  localparam logic [2:0] MODE_VBF       = 3'd0;
  localparam logic [2:0] MODE_BINS3     = 3'd1;
  localparam logic [2:0] MODE_BINS3_VBF = 3'd2;
  localparam logic [2:0] MODE_BINS2     = 3'd3;
  localparam logic [2:0] MODE_BINS2_VBF = 3'd4;

  // category codes
  localparam logic [2:0] CAT_NONE   = 3'd0;
  localparam logic [2:0] CAT_VBF    = 3'd1;
  localparam logic [2:0] CAT_NOVBF  = 3'd2;
  localparam logic [2:0] CAT_EQ0    = 3'd3;
  localparam logic [2:0] CAT_EQ1    = 3'd4;
  localparam logic [2:0] CAT_GEQ2   = 3'd5;
  localparam logic [2:0] CAT_GEQ1   = 3'd6;

  typedef enum logic [1:0] {
    POS_NONE  = 2'd0,
    POS_FIRST = 2'd1,
    POS_PAIR  = 2'd2
  } jmv_pos_t;

  typedef enum logic {
    OP_PAIR = 1'b0,
    OP_END  = 1'b1
  } jmv_kind_t;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] jet_px;
    logic signed [15:0] jet_py;
    logic signed [15:0] jet_pz;
    logic [15:0]        jet_energy;
    logic [15:0]        jet_pt;
    logic signed [11:0] jet_eta;
    logic signed [11:0] boson_eta;
  } jmv_in_t;

  typedef struct packed {
    logic [2:0] category;
    logic [7:0] jet_count;
    logic       vbf_tag;
  } jmv_out_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] pt_thr;
    logic [11:0] gap_cut;
    logic [15:0] mass_cut;
  } jmv_cfg_t;

  // word passed from front to back
  typedef struct packed {
    jmv_kind_t          kind;
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [16:0] sz;
    logic [16:0]        se;
    logic [7:0]         jet_count;
    logic               vbf_pre;
  } jmv_op_t;

endpackage

>>> rtl/jmv_fifo.sv
// Small show-ahead queue built on a register array.
module jmv_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  T                           wr_data,
  input  logic                       rd_en,
  output T                           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                   entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign rd_data = entries_r[rd_ptr_r];
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;

  // writers and readers must honor the flags
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(rd_en && empty))
    else $error("queue read while empty");

endmodule

>>> rtl/jmv_front.sv
// Front end: takes jet and end words, keeps per-event state, issues pair and end ops.
module jmv_front import jmv_pkg::*; #(
  parameter int MAX_JET_COUNT = JMV_MAX_JET_COUNT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  jmv_cfg_t cfg,
  input  logic     accept,
  input  jmv_in_t  in_word,
  output logic     op_valid,
  output jmv_op_t  op
);

  localparam int CNT_W = $clog2(MAX_JET_COUNT + 1);

  jmv_pos_t           pos_r, pos_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [15:0] first_px_r, first_px_nxt;
  logic signed [15:0] first_py_r, first_py_nxt;
  logic signed [15:0] first_pz_r, first_pz_nxt;
  logic [15:0]        first_en_r, first_en_nxt;
  logic signed [11:0] first_eta_r, first_eta_nxt;
  logic signed [11:0] lower_eta_r, lower_eta_nxt;
  logic signed [11:0] upper_eta_r, upper_eta_nxt;
  logic               gap_ok_r, gap_ok_nxt;
  logic               central_r, central_nxt;

  logic signed [12:0] eta_diff;
  logic [12:0]        gap_abs;
  logic               boson_central;
  logic               is_end;

  assign is_end   = (in_word.opcode == OPC_END);
  assign eta_diff = 13'(first_eta_r) - 13'(in_word.jet_eta);
  assign gap_abs  = eta_diff[12] ? 13'(-eta_diff) : 13'(eta_diff);
  assign boson_central = (pos_r == POS_PAIR) && (in_word.boson_eta > lower_eta_r)
                         && (in_word.boson_eta < upper_eta_r);

  // next event state
  always_comb begin
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    first_px_nxt  = first_px_r;
    first_py_nxt  = first_py_r;
    first_pz_nxt  = first_pz_r;
    first_en_nxt  = first_en_r;
    first_eta_nxt = first_eta_r;
    lower_eta_nxt = lower_eta_r;
    upper_eta_nxt = upper_eta_r;
    gap_ok_nxt    = gap_ok_r;
    central_nxt   = central_r;
    if (accept) begin
      if (is_end) begin
        pos_nxt       = POS_NONE;
        cnt_nxt       = '0;
        first_px_nxt  = '0;
        first_py_nxt  = '0;
        first_pz_nxt  = '0;
        first_en_nxt  = '0;
        first_eta_nxt = '0;
        lower_eta_nxt = '0;
        upper_eta_nxt = '0;
        gap_ok_nxt    = 1'b0;
        central_nxt   = 1'b0;
      end else begin
        if ((in_word.jet_pt > cfg.pt_thr) && (cnt_r < CNT_W'(MAX_JET_COUNT))) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        case (pos_r)
          POS_NONE: begin
            first_px_nxt  = in_word.jet_px;
            first_py_nxt  = in_word.jet_py;
            first_pz_nxt  = in_word.jet_pz;
            first_en_nxt  = in_word.jet_energy;
            first_eta_nxt = in_word.jet_eta;
            pos_nxt       = POS_FIRST;
          end
          POS_FIRST: begin
            if (first_eta_r < in_word.jet_eta) begin
              lower_eta_nxt = first_eta_r;
              upper_eta_nxt = in_word.jet_eta;
            end else begin
              lower_eta_nxt = in_word.jet_eta;
              upper_eta_nxt = first_eta_r;
            end
            gap_ok_nxt = (gap_abs > {1'b0, cfg.gap_cut});
            pos_nxt    = POS_PAIR;
          end
          POS_PAIR: begin
            if ((in_word.jet_pt >= cfg.pt_thr) && (in_word.jet_eta > lower_eta_r)
                && (in_word.jet_eta < upper_eta_r)) begin
              central_nxt = 1'b1;
            end
          end
          default: begin
            pos_nxt = POS_NONE;
          end
        endcase
      end
    end
  end

  // ops toward the back end: pair sums on the second jet, summary on the end word
  always_comb begin
    op_valid     = accept && (is_end || (pos_r == POS_FIRST));
    op.kind      = is_end ? OP_END : OP_PAIR;
    op.sx        = 17'(first_px_r) + 17'(in_word.jet_px);
    op.sy        = 17'(first_py_r) + 17'(in_word.jet_py);
    op.sz        = 17'(first_pz_r) + 17'(in_word.jet_pz);
    op.se        = {1'b0, first_en_r} + {1'b0, in_word.jet_energy};
    op.jet_count = (32'(cnt_r) > 32'd255) ? 8'hFF : 8'(cnt_r);
    op.vbf_pre   = (cnt_r >= CNT_W'(2)) && gap_ok_r && !central_r && boson_central;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_NONE;
      cnt_r       <= '0;
      first_px_r  <= '0;
      first_py_r  <= '0;
      first_pz_r  <= '0;
      first_en_r  <= '0;
      first_eta_r <= '0;
      lower_eta_r <= '0;
      upper_eta_r <= '0;
      gap_ok_r    <= 1'b0;
      central_r   <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      first_px_r  <= first_px_nxt;
      first_py_r  <= first_py_nxt;
      first_pz_r  <= first_pz_nxt;
      first_en_r  <= first_en_nxt;
      first_eta_r <= first_eta_nxt;
      lower_eta_r <= lower_eta_nxt;
      upper_eta_r <= upper_eta_nxt;
      gap_ok_r    <= gap_ok_nxt;
      central_r   <= central_nxt;
    end
  end

  // a tag candidate needs a complete pair
  a_vbf_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
      (op_valid && op.kind == OP_END && op.vbf_pre) |-> (pos_r == POS_PAIR))
    else $error("vbf candidate without a jet pair");

endmodule

>>> rtl/jmv_back.sv
// Back end: pair mass pipeline and category decision.
module jmv_back import jmv_pkg::*; #(
  parameter int OUT_DEPTH = JMV_OUT_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  jmv_cfg_t                       cfg,
  input  logic                           op_empty,
  input  jmv_op_t                        op,
  output logic                           op_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_valid,
  output jmv_out_t                       res
);

  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  // stage 1: squares
  logic               v1_r;
  jmv_kind_t          k1_r;
  logic [33:0]        sqe_r, sqx_r, sqy_r, sqz_r;
  logic [31:0]        cut2_1_r;
  logic [7:0]         cnt1_r;
  logic               vbf1_r;
  // stage 2: partial sums
  logic               v2_r;
  jmv_kind_t          k2_r;
  logic signed [35:0] d1_r;
  logic [34:0]        d2_r;
  logic [31:0]        cut2_2_r;
  logic [7:0]         cnt2_r;
  logic               vbf2_r;

  logic               mass_ok_r, mass_ok_nxt;
  logic signed [33:0] sqx, sqy, sqz;
  logic [33:0]        sqe;
  logic signed [35:0] m2;
  logic               vbf;
  logic [2:0]         bins3, bins2;
  logic [OCNT_W+1:0]  pending;

  // keep room in the result queue for everything in flight
  assign pending = (OCNT_W + 2)'(out_count) + (OCNT_W + 2)'(v1_r) + (OCNT_W + 2)'(v2_r);
  assign op_pop  = !op_empty && (pending < (OCNT_W + 2)'(OUT_DEPTH));

  assign sqx = op.sx * op.sx;
  assign sqy = op.sy * op.sy;
  assign sqz = op.sz * op.sz;
  assign sqe = {17'd0, op.se} * {17'd0, op.se};

  always_ff @(posedge clk) begin
    k1_r     <= op.kind;
    sqe_r    <= sqe;
    sqx_r    <= sqx;
    sqy_r    <= sqy;
    sqz_r    <= sqz;
    cut2_1_r <= cfg.mass_cut * cfg.mass_cut;
    cnt1_r   <= op.jet_count;
    vbf1_r   <= op.vbf_pre;

    k2_r     <= k1_r;
    d1_r     <= $signed({2'b00, sqe_r}) - $signed({2'b00, sqx_r});
    d2_r     <= {1'b0, sqy_r} + {1'b0, sqz_r};
    cut2_2_r <= cut2_1_r;
    cnt2_r   <= cnt1_r;
    vbf2_r   <= vbf1_r;
  end

  // stage 3: mass test for pairs, category for end words
  assign m2 = d1_r - $signed({1'b0, d2_r});

  always_comb begin
    mass_ok_nxt = mass_ok_r;
    if (v2_r && (k2_r == OP_PAIR)) begin
      mass_ok_nxt = (m2 > $signed({4'd0, cut2_2_r}));
    end
  end

  assign vbf   = vbf2_r && mass_ok_r;
  assign bins3 = (cnt2_r == 8'd0) ? CAT_EQ0 : ((cnt2_r == 8'd1) ? CAT_EQ1 : CAT_GEQ2);
  assign bins2 = (cnt2_r == 8'd0) ? CAT_EQ0 : CAT_GEQ1;

  always_comb begin
    res_valid     = v2_r && (k2_r == OP_END);
    res.jet_count = cnt2_r;
    res.vbf_tag   = vbf;
    case (cfg.mode)
      MODE_VBF:       res.category = vbf ? CAT_VBF : CAT_NOVBF;
      MODE_BINS3:     res.category = bins3;
      MODE_BINS3_VBF: res.category = vbf ? CAT_VBF : bins3;
      MODE_BINS2:     res.category = bins2;
      MODE_BINS2_VBF: res.category = vbf ? CAT_VBF : bins2;
      default:        res.category = CAT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      mass_ok_r <= 1'b0;
    end else begin
      v1_r      <= op_pop;
      v2_r      <= v1_r;
      mass_ok_r <= mass_ok_nxt;
    end
  end

  // reservation must never let results outrun the queue
  a_reserve: assert property (@(posedge clk) disable iff (!rst_n)
      pending <= (OCNT_W + 2)'(OUT_DEPTH))
    else $error("result queue reservation exceeded");

endmodule

>>> rtl/jet_multiplicity_vbf_categorizer.sv
// Top level of the jet multiplicity / VBF event categorizer.
//
//   channel   direction  handshake            payload
//   in_*      input      in_push / in_full    jmv_in_t  (jet or end-of-event word)
//   out_*     output     out_pop / out_empty  jmv_out_t (one word per event)
//   cfg_*     input      cfg_we               cfg_addr, cfg_wdata (16 bits)
//
// One word is accepted per cycle while in_full is low; jet words produce
// nothing, an end word enters the middle queue when it is accepted, then
// passes the two back stages and the result-queue write to reach out_data.
// The back end reserves result-queue room for its two pipeline stages, so it
// sustains one word per cycle while out_pop is held high.
// Reset (rst_n low, synchronous) clears event state, queues and registers.
// in_full rises only when the front-to-back queue is full; a stalled consumer
// backs up the result queue, then the middle queue, then the input.
module jet_multiplicity_vbf_categorizer import jmv_pkg::*; #(
  parameter int MAX_JET_COUNT = JMV_MAX_JET_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  // jet / end words
  input  logic        in_push,
  output logic        in_full,
  input  jmv_in_t     in_data,
  // event results
  output logic        out_empty,
  input  logic        out_pop,
  output jmv_out_t    out_data,
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int MID_CNT_W = $clog2(JMV_MID_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(JMV_OUT_DEPTH + 1);

  jmv_cfg_t             cfg_r;
  logic                 in_accept;
  logic                 op_valid;
  jmv_op_t              op_wr;
  jmv_op_t              op_rd;
  logic                 mid_full, mid_empty, mid_pop;
  logic [MID_CNT_W-1:0] mid_count;
  logic                 res_valid;
  jmv_out_t             res;
  logic                 out_full;
  logic [OUT_CNT_W-1:0] out_count;

  // configuration registers; the user is to write them only while the block is idle, which the block leaves unenforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= RST_MODE;
      cfg_r.pt_thr   <= RST_PT_THR;
      cfg_r.gap_cut  <= RST_GAP_CUT;
      cfg_r.mass_cut <= RST_MASS_CUT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:     cfg_r.mode     <= cfg_wdata[2:0];
        REG_PT_THR:   cfg_r.pt_thr   <= cfg_wdata;
        REG_GAP_CUT:  cfg_r.gap_cut  <= cfg_wdata[11:0];
        REG_MASS_CUT: cfg_r.mass_cut <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_full   = mid_full;
  assign in_accept = in_push && !mid_full;

  jmv_front #(
    .MAX_JET_COUNT(MAX_JET_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (in_accept),
    .in_word  (in_data),
    .op_valid (op_valid),
    .op       (op_wr)
  );

  // decouples the event tracker from the mass pipeline
  jmv_fifo #(
    .T     (jmv_op_t),
    .DEPTH (JMV_MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (op_valid),
    .wr_data (op_wr),
    .rd_en   (mid_pop),
    .rd_data (op_rd),
    .full    (mid_full),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  jmv_back #(
    .OUT_DEPTH(JMV_OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_empty  (mid_empty),
    .op        (op_rd),
    .op_pop    (mid_pop),
    .out_count (out_count),
    .res_valid (res_valid),
    .res       (res)
  );

  jmv_fifo #(
    .T     (jmv_out_t),
    .DEPTH (JMV_OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (out_pop && !out_empty),
    .rd_data (out_data),
    .full    (out_full),
    .empty   (out_empty),
    .count   (out_count)
  );

  // queue flags agree with their fill counts; no result goes into a full queue
  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
      mid_full |-> (mid_count == MID_CNT_W'(JMV_MID_DEPTH)))
    else $error("middle queue full flag out of step");
  a_out_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
      out_full |-> !res_valid)
    else $error("result produced into a full queue");

endmodule

>>> verif/jet_multiplicity_vbf_categorizer_tb.sv
// Testbench for the jet multiplicity / VBF categorizer: directed and random events checked by a predictor.
module jet_multiplicity_vbf_categorizer_tb;
  import jmv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 10;    // > front + queue + two back stages
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 120;   // long receiver stall for the pressure test

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  jmv_in_t     in_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  jmv_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  jet_multiplicity_vbf_categorizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and the running event.
  // ---------------------------------------------------------------------------
  logic [2:0]  reg_mode;
  logic [15:0] reg_pt_thr;
  logic [11:0] reg_gap_cut;
  logic [15:0] reg_mass_cut;

  jmv_pos_t    jet_pos;
  int          n_counted;
  longint      first_px, first_py, first_pz, first_en;
  int          first_eta, lo_eta, hi_eta;
  bit          pair_ok;
  bit          central_seen;

  jmv_out_t    expected_verdicts[$];   // one per end word, oldest first
  int          mismatches = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  int          holds_asked = 0;

  function automatic void clear_event();
    jet_pos      = POS_NONE;
    n_counted    = 0;
    first_px     = 0;
    first_py     = 0;
    first_pz     = 0;
    first_en     = 0;
    first_eta    = 0;
    lo_eta       = 0;
    hi_eta       = 0;
    pair_ok      = 1'b0;
    central_seen = 1'b0;
  endfunction

  // Advance the event by one accepted word; end words queue a verdict.
  function automatic void classify_word(input jmv_in_t w);
    int       eta;
    int       beta;
    int       gap;
    longint   sx, sy, sz, se, m2, cut2;
    bit       inner;
    bit       vbf;
    logic [2:0] bins3, bins2;
    jmv_out_t r;
    if (w.opcode == OPC_JET) begin
      eta = int'($signed(w.jet_eta));
      if (w.jet_pt > reg_pt_thr && n_counted < JMV_MAX_JET_COUNT) n_counted++;
      case (jet_pos)
        POS_NONE: begin
          first_px  = longint'($signed(w.jet_px));
          first_py  = longint'($signed(w.jet_py));
          first_pz  = longint'($signed(w.jet_pz));
          first_en  = longint'(w.jet_energy);
          first_eta = eta;
          jet_pos   = POS_FIRST;
        end
        POS_FIRST: begin
          // pair mass squared against the squared cut; spacelike pairs fail
          sx   = first_px + longint'($signed(w.jet_px));
          sy   = first_py + longint'($signed(w.jet_py));
          sz   = first_pz + longint'($signed(w.jet_pz));
          se   = first_en + longint'(w.jet_energy);
          m2   = se * se - sx * sx - sy * sy - sz * sz;
          cut2 = longint'(reg_mass_cut) * longint'(reg_mass_cut);
          gap  = first_eta - eta;
          if (gap < 0) gap = -gap;
          if (first_eta < eta) begin
            lo_eta = first_eta;
            hi_eta = eta;
          end else begin
            lo_eta = eta;
            hi_eta = first_eta;
          end
          pair_ok = (gap > int'(reg_gap_cut)) && (m2 > cut2);
          jet_pos = POS_PAIR;
        end
        default: begin
          // later jets at or above threshold veto when strictly inside the gap
          if (w.jet_pt >= reg_pt_thr && eta > lo_eta && eta < hi_eta) central_seen = 1'b1;
        end
      endcase
    end else begin
      beta  = int'($signed(w.boson_eta));
      inner = (jet_pos == POS_PAIR) && beta > lo_eta && beta < hi_eta;
      vbf   = (n_counted >= 2) && pair_ok && !central_seen && inner;
      bins3 = (n_counted == 0) ? CAT_EQ0 : ((n_counted == 1) ? CAT_EQ1 : CAT_GEQ2);
      bins2 = (n_counted == 0) ? CAT_EQ0 : CAT_GEQ1;
      case (reg_mode)
        MODE_VBF:       r.category = vbf ? CAT_VBF : CAT_NOVBF;
        MODE_BINS3:     r.category = bins3;
        MODE_BINS3_VBF: r.category = vbf ? CAT_VBF : bins3;
        MODE_BINS2:     r.category = bins2;
        MODE_BINS2_VBF: r.category = vbf ? CAT_VBF : bins2;
        default:        r.category = CAT_NONE;
      endcase
      r.jet_count = 8'(n_counted);
      r.vbf_tag   = vbf;
      expected_verdicts = {expected_verdicts, r};
      clear_event();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random pops, long holds on request, field-by-field compare.
  // ---------------------------------------------------------------------------
  function automatic void check_verdict(input jmv_out_t got);
    jmv_out_t want;
    if (expected_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected word cat=%0d cnt=%0d vbf=%0d", $realtime,
                 got.category, got.jet_count, got.vbf_tag);
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.category !== want.category || got.jet_count !== want.jet_count ||
        got.vbf_tag !== want.vbf_tag) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp cat=%0d cnt=%0d vbf=%0d, got cat=%0d cnt=%0d vbf=%0d",
                 $realtime, want.category, want.jet_count, want.vbf_tag,
                 got.category, got.jet_count, got.vbf_tag);
    end
  endfunction

  int hold_left = 0;
  int holds_served = 0;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_verdict(out_data);
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= !(idle_on && $urandom_range(99) < 10);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then run it through the predictor.
  // Called at a rising edge; returns at the edge of acceptance.
  task automatic send_word(input jmv_in_t w);
    if (idle_on && $urandom_range(99) < 10) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_full);
    words_sent++;
    classify_word(w);
  endtask

  // Registers change only with the block drained and settled.
  task automatic configure(input logic [2:0] mode, input logic [15:0] thr,
                           input logic [11:0] gap, input logic [15:0] mass);
    in_push <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MODE;
    cfg_wdata <= {13'($urandom), mode};       // upper bits must be ignored
    @(posedge clk);
    reg_mode   = mode;
    cfg_addr  <= REG_PT_THR;
    cfg_wdata <= thr;
    @(posedge clk);
    reg_pt_thr = thr;
    cfg_addr  <= REG_GAP_CUT;
    cfg_wdata <= {4'($urandom), gap};
    @(posedge clk);
    reg_gap_cut = gap;
    cfg_addr  <= REG_MASS_CUT;
    cfg_wdata <= mass;
    @(posedge clk);
    reg_mass_cut = mass;
    cfg_we <= 1'b0;
  endtask

  task automatic configure_random();
    logic [15:0] thr;
    logic [11:0] gap;
    logic [15:0] mass;
    thr  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(60, 400));
    gap  = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(400, 1500));
    mass = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
    configure(3'($urandom), thr, gap, mass);
  endtask

  function automatic jmv_in_t random_word();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return jmv_in_t'(r[$bits(jmv_in_t)-1:0]);
  endfunction

  function automatic jmv_in_t make_jet(input int px, input int py, input int pz,
                                       input int en, input int pt, input int eta);
    jmv_in_t w;
    w            = '0;
    w.opcode     = OPC_JET;
    w.jet_px     = 16'(px);
    w.jet_py     = 16'(py);
    w.jet_pz     = 16'(pz);
    w.jet_energy = 16'(en);
    w.jet_pt     = 16'(pt);
    w.jet_eta    = 12'(eta);
    return w;
  endfunction

  function automatic jmv_in_t make_end(input int beta);
    jmv_in_t w;
    w           = '0;
    w.opcode    = OPC_END;
    w.boson_eta = 12'(beta);
    return w;
  endfunction

  // One event of n_jets jets plus its end word. Shaped events look like VBF
  // candidates (forward/backward pair, falling pt) so the later cuts get
  // exercised; unshaped ones carry fully random content.
  task automatic send_event(input int n_jets, input bit shaped);
    jmv_in_t w;
    int      k;
    int      pt_prev;
    int      lead_sgn;
    int      sgn;
    int      eta_v;
    int      pz_v;
    int      en_v;
    int      pt_v;
    pt_prev  = 65535;
    lead_sgn = 1;
    for (k = 0; k < n_jets; k++) begin
      w        = random_word();
      w.opcode = OPC_JET;
      if (shaped) begin
        if (k < 2) begin
          if (k == 0) begin
            lead_sgn = $urandom_range(1) ? 1 : -1;
            sgn      = lead_sgn;
          end else begin
            sgn = ($urandom_range(4) == 0) ? lead_sgn : -lead_sgn;
          end
          eta_v = sgn * int'($urandom_range(150, 1280));
          pz_v  = sgn * int'($urandom_range(3000, 30000));
          en_v  = (pz_v < 0 ? -pz_v : pz_v) + int'($urandom_range(0, 20000));
          if (en_v > 65535) en_v = 65535;
          w.jet_px     = 16'(int'($urandom_range(0, 6000)) - 3000);
          w.jet_py     = 16'(int'($urandom_range(0, 6000)) - 3000);
          w.jet_pz     = 16'(pz_v);
          w.jet_energy = 16'(en_v);
          w.jet_eta    = 12'(eta_v);
          pt_v = (k == 0) ? int'($urandom_range(300, 8000)) : int'($urandom_range(0, pt_prev));
        end else begin
          w.jet_eta = 12'(int'($urandom_range(0, 2560)) - 1280);
          if ($urandom_range(3) == 0) begin
            // right at the threshold, where the count and the veto disagree
            pt_v = int'(reg_pt_thr) + int'($urandom_range(0, 2)) - 1;
            if (pt_v < 0) pt_v = 0;
            if (pt_v > 65535) pt_v = 65535;
          end else begin
            pt_v = int'($urandom_range(0, pt_prev));
          end
        end
        w.jet_pt = 16'(pt_v);
        pt_prev  = pt_v;
      end
      send_word(w);
    end
    w        = random_word();
    w.opcode = OPC_END;
    if (shaped && $urandom_range(9) < 7) w.boson_eta = 12'(int'($urandom_range(0, 1200)) - 600);
    send_word(w);
  endtask

  function automatic int pick_jet_count();
    return ($urandom_range(4) == 0) ? int'($urandom_range(0, 12)) : int'($urandom_range(2, 4));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Leading pair that passes every cut at the reset settings.
  task automatic send_good_pair();
    send_word(make_jet(0, 0, 20000, 25000, 4000, 600));
    send_word(make_jet(0, 0, -20000, 25000, 3000, -600));
  endtask

  // Special cases at reset settings (vbf/novbf mode).
  task automatic test_directed();
    send_word(make_end(0));                                   // empty event
    send_word(make_jet(0, 0, 0, 200, 121, 100));              // single jet
    send_word(make_end(0));
    send_good_pair();                                         // clean VBF
    send_word(make_end(0));
    send_good_pair();                                         // central jet at threshold vetoes
    send_word(make_jet(0, 0, 0, 500, 120, 0));
    send_word(make_end(10));
    send_good_pair();                                         // one below threshold does not
    send_word(make_jet(0, 0, 0, 500, 119, 0));
    send_word(make_end(-599));
    send_good_pair();                                         // boson on the edge
    send_word(make_end(600));
    send_word(make_jet(32767, 0, 0, 0, 200, 1000));           // spacelike pair
    send_word(make_jet(32767, 0, 0, 0, 200, -1000));
    send_word(make_end(0));
    send_word(make_jet(-32768, -32768, -32768, 65535, 65535, -2048));   // field extremes
    send_word(make_jet(32767, 32767, 32767, 65535, 65535, 2047));
    send_word(make_jet(0, 0, 0, 0, 0, 0));
    send_word(make_end(-2048));
  endtask

  // Every category scheme, including the unused codes.
  task automatic test_modes();
    int m;
    for (m = 0; m < 8; m++) begin
      configure(3'(m), RST_PT_THR, RST_GAP_CUT, RST_MASS_CUT);
      send_event(0, 1'b1);
      send_event(1, 1'b1);
      send_event(int'($urandom_range(2, 4)), 1'b1);
    end
  endtask

  // Cut registers at their extremes.
  task automatic test_cut_extremes();
    configure(MODE_BINS3_VBF, 16'd0, 12'd0, 16'd0);
    repeat (4) send_event(pick_jet_count(), 1'b1);
    configure(MODE_BINS2_VBF, 16'hFFFF, 12'hFFF, 16'hFFFF);
    repeat (4) send_event(pick_jet_count(), 1'b1);
    configure(MODE_VBF, RST_PT_THR, 12'd2560, 16'd0);
    repeat (4) send_event(pick_jet_count(), 1'b1);
    configure(MODE_VBF, 16'd0, 12'd0, 16'hFFFF);
    repeat (4) send_event(pick_jet_count(), 1'b1);
  endtask

  // Mostly shaped events, some random ones and bursts of noise words.
  task automatic run_random_traffic(input int n_words);
    int stop_at;
    int next_cfg;
    stop_at  = words_sent + n_words;
    next_cfg = words_sent + 60;
    while (words_sent < stop_at) begin
      if (words_sent >= next_cfg) begin
        configure_random();
        next_cfg = words_sent + int'($urandom_range(40, 90));
      end
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 6)) send_word(random_word());
      end else begin
        send_event(pick_jet_count(), $urandom_range(9) != 0);
      end
    end
    send_event(pick_jet_count(), 1'b1);   // close any event a noise burst left open
  endtask

  // No idling on either side.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_random_traffic(60);
    idle_on = 1'b1;
  endtask

  // Receiver stalls long while words keep coming, so in_full must rise.
  task automatic test_backpressure();
    jmv_in_t w;
    holds_asked++;
    repeat (30) begin
      w        = random_word();
      w.opcode = OPC_END;
      send_word(w);
    end
    repeat (6) send_event(pick_jet_count(), 1'b1);
  endtask

  // Jet count saturates.
  task automatic test_count_saturation();
    jmv_in_t w;
    configure(MODE_BINS3, 16'd0, RST_GAP_CUT, RST_MASS_CUT);
    repeat (JMV_MAX_JET_COUNT + 5) begin
      w        = random_word();
      w.opcode = OPC_JET;
      w.jet_pt = 16'($urandom_range(1, 65535));
      send_word(w);
    end
    send_word(make_end(0));
    send_word(make_jet(0, 0, 0, 0, 0, 0));    // pt 0 is not above a zero threshold
    send_word(make_end(0));
  endtask

  initial begin
    reg_mode     = RST_MODE;
    reg_pt_thr   = RST_PT_THR;
    reg_gap_cut  = RST_GAP_CUT;
    reg_mass_cut = RST_MASS_CUT;
    clear_event();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_modes();
    test_cut_extremes();
    configure(RST_MODE, RST_PT_THR, RST_GAP_CUT, RST_MASS_CUT);
    run_random_traffic(40);
    test_steady_stream();
    test_backpressure();
    test_count_saturation();
    configure_random();
    run_random_traffic(30);

    in_push <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/jmv_pkg.sv
rtl/jmv_fifo.sv
rtl/jmv_front.sv
rtl/jmv_back.sv
rtl/jet_multiplicity_vbf_categorizer.sv
verif/jet_multiplicity_vbf_categorizer_tb.sv
